// ===== rtl/core/nfcfr_pkg.sv =====
package nfcfr_pkg;

   localparam logic [7:0] StartLead  = 8'h00;
   localparam logic [7:0] StartCode  = 8'hFF;
   localparam logic [7:0] AckLen     = 8'h00;
   localparam logic [7:0] AckLcs     = 8'hFF;
   localparam logic [7:0] HeaderLen  = 8'd2;

   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_LEN  = 4'd1,
      PH_LCS  = 4'd2,
      PH_TFI  = 4'd3,
      PH_CMD  = 4'd4,
      PH_DATA = 4'd5,
      PH_DCS  = 4'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_ACK  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_GOOD    = 2'd0,
      ST_LCS_BAD = 2'd1,
      ST_DCS_BAD = 2'd2,
      ST_SHORT   = 2'd3
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [7:0] command_code;
      logic [7:0] payload_count;
      status_type status;
      logic       frame_last;
   } rsp_type;

endpackage

// ===== rtl/core/nfcfr_req_if.sv =====
interface nfcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/nfcfr_rsp_if.sv =====
interface nfcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic [7:0] command_code;
   logic [7:0] payload_count;
   logic [1:0] status;
   logic       frame_last;

   modport source (
      output valid, output kind, output payload_byte, output command_code,
      output payload_count, output status, output frame_last, input ready
   );
   modport sink (
      input valid, input kind, input payload_byte, input command_code,
      input payload_count, input status, input frame_last, output ready
   );
endinterface

// ===== rtl/core/nfc_frame_receiver_unit.sv =====
// A request's byte is held in an input register and any result it yields in a
// result register; a full result register that is not taken stalls the input.
// Throughput: one request per cycle while the output is not stalled; a request
// may be accepted while the previous result still waits on the output.
// Reset is synchronous and active high; it empties both registers and puts
// the parser back to hunting for the start code.
module nfc_frame_receiver_unit (
   input  logic clock,
   input  logic reset,
   nfcfr_req_if.sink   req_ch,
   nfcfr_rsp_if.source rsp_ch
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  out_valid_ff, out_valid_in;
   nfcfr_pkg::rsp_type    out_ff, out_in;

   nfcfr_pkg::phase_type  phase_ff, phase_in;
   logic                  saw_zero_ff, saw_zero_in;
   logic [7:0]            frame_length_ff, frame_length_in;
   logic [7:0]            bytes_left_ff, bytes_left_in;
   logic [7:0]            running_sum_ff, running_sum_in;
   logic [7:0]            held_command_ff, held_command_in;

   logic                  work_go;
   logic                  req_fire;
   logic                  emit;
   logic [7:0]            sum_next;
   logic [7:0]            left_next;
   nfcfr_pkg::rsp_type    res;

   assign work_go      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || work_go;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign sum_next     = running_sum_ff + in_byte_ff;
   assign left_next    = bytes_left_ff - 8'd1;

   always_comb begin
      phase_in        = phase_ff;
      saw_zero_in     = saw_zero_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      held_command_in = held_command_ff;
      emit            = 1'b0;
      res             = '{kind: nfcfr_pkg::KIND_DATA, payload_byte: 8'd0,
                          command_code: 8'd0, payload_count: 8'd0,
                          status: nfcfr_pkg::ST_GOOD, frame_last: 1'b0};
      unique case (phase_ff)
         nfcfr_pkg::PH_LEN: begin
            frame_length_in = in_byte_ff;
            phase_in        = nfcfr_pkg::PH_LCS;
         end
         nfcfr_pkg::PH_LCS: begin
            if (frame_length_ff == nfcfr_pkg::AckLen && in_byte_ff == nfcfr_pkg::AckLcs) begin
               phase_in       = nfcfr_pkg::PH_HUNT;
               saw_zero_in    = 1'b0;
               emit           = 1'b1;
               res.kind       = nfcfr_pkg::KIND_ACK;
               res.frame_last = 1'b1;
            end else if (8'(frame_length_ff + in_byte_ff) != 8'd0) begin
               phase_in       = nfcfr_pkg::PH_HUNT;
               saw_zero_in    = 1'b0;
               emit           = 1'b1;
               res.kind       = nfcfr_pkg::KIND_END;
               res.status     = nfcfr_pkg::ST_LCS_BAD;
               res.frame_last = 1'b1;
            end else if (frame_length_ff < nfcfr_pkg::HeaderLen) begin
               phase_in       = nfcfr_pkg::PH_HUNT;
               saw_zero_in    = 1'b0;
               emit           = 1'b1;
               res.kind       = nfcfr_pkg::KIND_END;
               res.status     = nfcfr_pkg::ST_SHORT;
               res.frame_last = 1'b1;
            end else begin
               running_sum_in = 8'd0;
               phase_in       = nfcfr_pkg::PH_TFI;
            end
         end
         nfcfr_pkg::PH_TFI: begin
            running_sum_in = sum_next;
            phase_in       = nfcfr_pkg::PH_CMD;
         end
         nfcfr_pkg::PH_CMD: begin
            running_sum_in  = sum_next;
            held_command_in = in_byte_ff - 8'd1;
            bytes_left_in   = frame_length_ff - nfcfr_pkg::HeaderLen;
            phase_in        = (frame_length_ff == nfcfr_pkg::HeaderLen) ?
                              nfcfr_pkg::PH_DCS : nfcfr_pkg::PH_DATA;
         end
         nfcfr_pkg::PH_DATA: begin
            running_sum_in   = sum_next;
            bytes_left_in    = left_next;
            if (left_next == 8'd0) begin
               phase_in = nfcfr_pkg::PH_DCS;
            end
            emit             = 1'b1;
            res.payload_byte = in_byte_ff;
         end
         nfcfr_pkg::PH_DCS: begin
            running_sum_in    = sum_next;
            phase_in          = nfcfr_pkg::PH_HUNT;
            saw_zero_in       = 1'b0;
            emit              = 1'b1;
            res.kind          = nfcfr_pkg::KIND_END;
            res.command_code  = held_command_ff;
            res.payload_count = frame_length_ff - nfcfr_pkg::HeaderLen;
            res.status        = (sum_next == 8'd0) ? nfcfr_pkg::ST_GOOD :
                                nfcfr_pkg::ST_DCS_BAD;
            res.frame_last    = 1'b1;
         end
         default: begin
            if (saw_zero_ff && in_byte_ff == nfcfr_pkg::StartCode) begin
               saw_zero_in = 1'b0;
               phase_in    = nfcfr_pkg::PH_LEN;
            end else begin
               phase_in    = nfcfr_pkg::PH_HUNT;
               saw_zero_in = (in_byte_ff == nfcfr_pkg::StartLead);
            end
         end
      endcase
   end

   always_comb begin
      in_byte_in   = req_fire ? req_ch.rx_byte : in_byte_ff;
      in_valid_in  = req_fire || (in_valid_ff && !work_go);
      out_valid_in = (out_valid_ff && !rsp_ch.ready) || (work_go && emit);
      out_in       = (work_go && emit) ? res : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= nfcfr_pkg::PH_HUNT;
         saw_zero_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (work_go) begin
            phase_ff    <= phase_in;
            saw_zero_ff <= saw_zero_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
      if (work_go) begin
         frame_length_ff <= frame_length_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
         held_command_ff <= held_command_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.kind          = out_ff.kind;
   assign rsp_ch.payload_byte  = out_ff.payload_byte;
   assign rsp_ch.command_code  = out_ff.command_code;
   assign rsp_ch.payload_count = out_ff.payload_count;
   assign rsp_ch.status        = out_ff.status;
   assign rsp_ch.frame_last    = out_ff.frame_last;

`ifndef SYNTH
   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == nfcfr_pkg::KIND_DATA) |->
      (!out_ff.frame_last && out_ff.status == nfcfr_pkg::ST_GOOD))
      else $error("payload result marked as frame end");

   a_dcs_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (work_go && phase_ff == nfcfr_pkg::PH_DCS) |=>
      (phase_ff == nfcfr_pkg::PH_HUNT && !saw_zero_ff))
      else $error("parser did not return to hunting after the data checksum");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == nfcfr_pkg::PH_DATA) |-> (bytes_left_ff != 8'd0))
      else $error("payload phase entered with no bytes left");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("input register empty but request not taken");
`endif

endmodule

// ===== tb/sv/nfc_frame_receiver_unit_checker.sv =====
module nfc_frame_receiver_unit_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_payload_byte,
   input  logic [7:0] rsp_command_code,
   input  logic [7:0] rsp_payload_count,
   input  logic [1:0] rsp_status,
   input  logic       rsp_frame_last,
   output int         fail_count,
   output int         due_count
);

   nfcfr_pkg::phase_type phase;
   logic                 zero_seen;
   logic [7:0]           frame_len;
   logic [7:0]           bytes_left;
   logic [7:0]           data_sum;
   logic [7:0]           held_cmd;
   nfcfr_pkg::rsp_type   deframed_due[$];
   int                   failures = 0;

   function void deframe_byte(input logic [7:0] b, output bit produced,
                              output nfcfr_pkg::rsp_type r);
      logic [7:0] len_check;
      produced = 1'b0;
      r = '0;
      case (phase)
         nfcfr_pkg::PH_LEN: begin
            frame_len = b;
            phase = nfcfr_pkg::PH_LCS;
         end
         nfcfr_pkg::PH_LCS: begin
            len_check = frame_len + b;
            produced = 1'b1;
            r.frame_last = 1'b1;
            phase = nfcfr_pkg::PH_HUNT;
            zero_seen = 1'b0;
            if (frame_len == nfcfr_pkg::AckLen && b == nfcfr_pkg::AckLcs) begin
               r.kind = nfcfr_pkg::KIND_ACK;
            end else if (len_check != 8'h00) begin
               r.kind = nfcfr_pkg::KIND_END;
               r.status = nfcfr_pkg::ST_LCS_BAD;
            end else if (frame_len < nfcfr_pkg::HeaderLen) begin
               r.kind = nfcfr_pkg::KIND_END;
               r.status = nfcfr_pkg::ST_SHORT;
            end else begin
               produced = 1'b0;
               r.frame_last = 1'b0;
               data_sum = 8'h00;
               phase = nfcfr_pkg::PH_TFI;
            end
         end
         nfcfr_pkg::PH_TFI: begin
            data_sum = data_sum + b;
            phase = nfcfr_pkg::PH_CMD;
         end
         nfcfr_pkg::PH_CMD: begin
            data_sum = data_sum + b;
            held_cmd = b - 8'd1;
            bytes_left = frame_len - nfcfr_pkg::HeaderLen;
            phase = (bytes_left == 8'd0) ? nfcfr_pkg::PH_DCS : nfcfr_pkg::PH_DATA;
         end
         nfcfr_pkg::PH_DATA: begin
            data_sum = data_sum + b;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
               phase = nfcfr_pkg::PH_DCS;
            end
            produced = 1'b1;
            r.kind = nfcfr_pkg::KIND_DATA;
            r.payload_byte = b;
         end
         nfcfr_pkg::PH_DCS: begin
            data_sum = data_sum + b;
            phase = nfcfr_pkg::PH_HUNT;
            zero_seen = 1'b0;
            produced = 1'b1;
            r.kind = nfcfr_pkg::KIND_END;
            r.command_code = held_cmd;
            r.payload_count = frame_len - nfcfr_pkg::HeaderLen;
            r.status = (data_sum == 8'h00) ? nfcfr_pkg::ST_GOOD : nfcfr_pkg::ST_DCS_BAD;
            r.frame_last = 1'b1;
         end
         default: begin
            if (zero_seen && b == nfcfr_pkg::StartCode) begin
               zero_seen = 1'b0;
               phase = nfcfr_pkg::PH_LEN;
            end else begin
               phase = nfcfr_pkg::PH_HUNT;
               zero_seen = (b == nfcfr_pkg::StartLead);
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      nfcfr_pkg::rsp_type want;
      nfcfr_pkg::rsp_type made;
      bit                 produced;
      if (reset) begin
         phase = nfcfr_pkg::PH_HUNT;
         zero_seen = 1'b0;
         frame_len = 8'h00;
         bytes_left = 8'h00;
         data_sum = 8'h00;
         held_cmd = 8'h00;
         deframed_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_due.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display({"unexpected result: kind %0d byte %02h cmd %02h",
                            " count %0d status %0d last %0b"},
                           rsp_kind, rsp_payload_byte, rsp_command_code,
                           rsp_payload_count, rsp_status, rsp_frame_last);
               end
            end else begin
               want = deframed_due.pop_front();
               if (rsp_kind !== want.kind || rsp_payload_byte !== want.payload_byte ||
                   rsp_command_code !== want.command_code ||
                   rsp_payload_count !== want.payload_count ||
                   rsp_status !== want.status || rsp_frame_last !== want.frame_last) begin
                  failures++;
                  if (failures <= 10) begin
                     $display({"mismatch: expected kind %0d byte %02h cmd %02h",
                               " count %0d status %0d last %0b"},
                              want.kind, want.payload_byte, want.command_code,
                              want.payload_count, want.status, want.frame_last);
                     $display({"          actual   kind %0d byte %02h cmd %02h",
                               " count %0d status %0d last %0b"},
                              rsp_kind, rsp_payload_byte, rsp_command_code,
                              rsp_payload_count, rsp_status, rsp_frame_last);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte, produced, made);
            if (produced) begin
               deframed_due = {deframed_due, made};
            end
         end
      end
      fail_count <= failures;
      due_count <= deframed_due.size();
   end

endmodule

// ===== tb/sv/nfc_frame_receiver_unit_tb.sv =====
module nfc_frame_receiver_unit_tb;

   localparam int FrameItemTarget = 1400;
   localparam int DrainSpacing = 300;
   localparam int IdleLimit = 2000;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_HOLD
   } rx_mode_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   due_count;
   int   burst_left;
   int   frame_items;
   int   next_drain;

   nfcfr_req_if req_ch();
   nfcfr_rsp_if rsp_ch();

   nfc_frame_receiver_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   nfc_frame_receiver_unit_checker u_frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_rx_byte       (req_ch.rx_byte),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_kind          (rsp_ch.kind),
      .rsp_payload_byte  (rsp_ch.payload_byte),
      .rsp_command_code  (rsp_ch.command_code),
      .rsp_payload_count (rsp_ch.payload_count),
      .rsp_status        (rsp_ch.status),
      .rsp_frame_last    (rsp_ch.frame_last),
      .fail_count        (fail_count),
      .due_count         (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_frame(input logic [7:0] len, input logic [7:0] lcs_skew,
                             input logic [7:0] tfi, input logic [7:0] code,
                             input logic [7:0] dcs_skew, input bit stripe_payload);
      logic [7:0] lcs;
      logic [7:0] sum;
      logic [7:0] value;
      lcs = 8'h00 - len + lcs_skew;
      send_byte(nfcfr_pkg::StartLead);
      send_byte(nfcfr_pkg::StartCode);
      send_byte(len);
      send_byte(lcs);
      frame_items += 4;
      if (lcs_skew != 8'h00 || len < nfcfr_pkg::HeaderLen) begin
         return;
      end
      sum = tfi + code;
      send_byte(tfi);
      send_byte(code);
      for (int i = 0; i < len - nfcfr_pkg::HeaderLen; i++) begin
         value = stripe_payload ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
         sum = sum + value;
         send_byte(value);
      end
      send_byte(8'h00 - sum + dcs_skew);
      frame_items += len + 1;
   endtask

   task automatic send_random_frame();
      int         pick;
      logic [7:0] len;
      logic [7:0] noise;
      pick = $urandom_range(0, 99);
      len = 8'(($urandom_range(0, 99) == 0) ? $urandom_range(200, 255)
                                             : $urandom_range(2, 16));
      if ($urandom_range(0, 7) == 0) begin
         send_byte(nfcfr_pkg::StartLead);
      end
      if (pick < 66) begin
         send_frame(len, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'h00, 1'b0);
      end else if (pick < 76) begin
         send_frame(len, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 82) begin
         send_frame(len, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'h00, 1'b0);
      end else if (pick < 86) begin
         send_frame(8'($urandom_range(0, 1)), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      end else if (pick < 91) begin
         send_frame(nfcfr_pkg::AckLen, nfcfr_pkg::AckLcs, 8'h00, 8'h00, 8'h00, 1'b0);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
               0: noise = nfcfr_pkg::StartLead;
               1: noise = nfcfr_pkg::StartCode;
               default: noise = 8'($urandom_range(0, 255));
            endcase
            send_byte(noise);
         end
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   initial begin
      rx_mode_type rx_mode;
      int          span;
      forever begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         span = (rx_mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(8, 64);
         repeat (span) begin
            case (rx_mode)
               RX_OPEN: rsp_ch.ready <= 1'b1;
               RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      burst_left = 0;
      frame_items = 0;
      next_drain = DrainSpacing;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_frame(nfcfr_pkg::AckLen, nfcfr_pkg::AckLcs, 8'h00, 8'h00, 8'h00, 1'b0);
      send_frame(8'h05, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
      send_frame(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_byte(nfcfr_pkg::StartLead);
      send_frame(8'h02, 8'h00, 8'hD5, 8'h00, 8'h00, 1'b0);
      send_frame(8'h04, 8'h00, 8'hFF, 8'hFF, 8'h80, 1'b1);
      drain_results();

      send_frame(8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'h00, 1'b0);
      while (frame_items < FrameItemTarget) begin
         send_random_frame();
         if (frame_items >= next_drain) begin
            drain_results();
            next_drain += DrainSpacing;
         end
      end
      drain_results();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && due_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/nfcfr_pkg.sv
rtl/core/nfcfr_req_if.sv
rtl/core/nfcfr_rsp_if.sv
rtl/core/nfc_frame_receiver_unit.sv
tb/sv/nfc_frame_receiver_unit_checker.sv
tb/sv/nfc_frame_receiver_unit_tb.sv
